[design/rtc_cal_pkg.sv]
// Package for the RTC calendar counter: shared types, calendar limits and
// the leap-year and month-length helpers. No dependencies.
package rtc_cal_pkg;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   localparam logic [5:0]  SEC_LAST   = 6'd59;
   localparam logic [5:0]  MIN_LAST   = 6'd59;
   localparam logic [4:0]  HOUR_LAST  = 5'd23;
   localparam logic [3:0]  MONTH_LAST = 4'd12;
   localparam logic [13:0] YEAR_LAST  = 14'd9999;

   localparam logic [15:0] TPS_RESET = 16'd1000;

   // Reciprocal of 25 scaled by 2^17; exact for every 14-bit year.
   localparam logic [26:0] RECIP_25 = 27'd5243;
   localparam logic [13:0] DIV_25   = 14'd25;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        leap;
   } cal_time_type;

   typedef struct packed {
      logic        kind;
      logic [5:0]  load_second;
      logic [5:0]  load_minute;
      logic [4:0]  load_hour;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [13:0] load_year;
   } cal_item_type;

   typedef struct packed {
      cal_time_type now;
      logic         second_strobe;
      logic         load_error;
   } cal_result_type;

   localparam cal_time_type TIME_RESET = '{
      second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1,
      month: 4'd1, year: 14'd0, leap: 1'b1
   };

   // Gregorian rule: divisible by 4, and not by 100 unless by 400.
   // Divisibility by 100 and 400 is divisibility by 4 or 16 and by 25.
   function automatic logic rtc_is_leap(input logic [13:0] year);
      logic [26:0] prod;
      logic [9:0]  quot;
      logic [13:0] rem;
      logic        div25;
      prod  = 27'(year) * RECIP_25;
      quot  = prod[26:17];
      rem   = year - 14'(quot * DIV_25);
      div25 = (rem == 14'd0);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [4:0] rtc_month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2:    days = leap ? 5'd29 : 5'd28;
         4'd4:    days = 5'd30;
         4'd6:    days = 5'd30;
         4'd9:    days = 5'd30;
         4'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

[design/rtc_cal_if.sv]
// Channel interfaces for the RTC calendar counter: request and response.
// Carries valid/ready and the payload fields. No dependencies.
interface rtc_cal_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [5:0]  load_second;
   logic [5:0]  load_minute;
   logic [4:0]  load_hour;
   logic [4:0]  load_day;
   logic [3:0]  load_month;
   logic [13:0] load_year;

   modport source (output valid, kind, load_second, load_minute, load_hour, load_day,
                   load_month, load_year, input ready);
   modport sink (input valid, kind, load_second, load_minute, load_hour, load_day,
                 load_month, load_year, output ready);
endinterface

interface rtc_cal_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  out_second;
   logic [5:0]  out_minute;
   logic [4:0]  out_hour;
   logic [4:0]  out_day;
   logic [3:0]  out_month;
   logic [13:0] out_year;
   logic        out_leap;
   logic        second_strobe;
   logic        load_error;

   modport source (output valid, out_second, out_minute, out_hour, out_day, out_month,
                   out_year, out_leap, second_strobe, load_error, input ready);
   modport sink (input valid, out_second, out_minute, out_hour, out_day, out_month,
                 out_year, out_leap, second_strobe, load_error, output ready);
endinterface

[design/rtc_calendar_counter_unit.sv]
// Top level of the RTC calendar counter: input register, prescaler, calendar
// state and a two-entry result buffer. Depends on rtc_cal_pkg, rtc_cal_if
// and rtc_cal_step.
//
// Usage:
// Items arrive on req_chan; kind selects a timer tick or a load of date and
// time. Every item gives exactly one result on rsp_chan with the date and
// time after the item, the leap flag, a second strobe for ticks that complete
// a second and an error flag for rejected loads.
// An item transferred on req_chan is registered; once the result buffer has
// room it updates the state and its result enters the buffer for rsp_chan.
// Throughput: one item per cycle while the buffer has room; the calendar
// carry is evaluated in one pass from input register to result buffer.
// The result buffer holds two entries, so a new item is taken while one
// result waits; when the receiver stalls long enough the buffer fills and
// req_chan.ready drops until a result is transferred.
// csr_wr_en/csr_wr_data write ticks per second; write it only while idle.
// Reset: synchronous, active high. Clears the prescaler, sets the clock to
// 00:00:00 on day 1 of month 1 of year 0 (a leap year) and ticks per second
// to 1000.
module rtc_calendar_counter_unit
   import rtc_cal_pkg::*;
#(
   parameter int PRESCALE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   rtc_cal_req_if.sink          req_chan,
   rtc_cal_rsp_if.source        rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);

   localparam int CMP_WIDTH = (PRESCALE_WIDTH + 1 > 16) ? PRESCALE_WIDTH + 1 : 17;

   logic [15:0]               tps_ff;
   logic [PRESCALE_WIDTH-1:0] prescale_ff, prescale_in;
   logic [PRESCALE_WIDTH:0]   presc_next;
   logic                      presc_wrap;
   logic                      second_done;

   logic          item_valid_ff;
   cal_item_type  item_ff;
   cal_time_type  time_ff;
   cal_result_type step_result;

   cal_result_type entry_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff, count_in;
   logic           push, pop, advance, take;
   cal_result_type head;

   // Input register; it moves on whenever the result buffer has room.
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign advance = item_valid_ff && ((count_ff != 2'd2) || pop);
   assign push    = advance;
   assign take    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind        <= req_chan.kind;
         item_ff.load_second <= req_chan.load_second;
         item_ff.load_minute <= req_chan.load_minute;
         item_ff.load_hour   <= req_chan.load_hour;
         item_ff.load_day    <= req_chan.load_day;
         item_ff.load_month  <= req_chan.load_month;
         item_ff.load_year   <= req_chan.load_year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_wr_en) begin
         tps_ff <= csr_wr_data;
      end
   end

   // The prescaler wraps when it reaches the programmed count or runs out
   // of bits; a count of zero therefore completes a second on every tick.
   assign presc_next  = {1'b0, prescale_ff} + (PRESCALE_WIDTH + 1)'(1);
   assign presc_wrap  = (CMP_WIDTH'(presc_next) >= CMP_WIDTH'(tps_ff)) ||
                        presc_next[PRESCALE_WIDTH];
   assign second_done = presc_wrap;
   assign prescale_in = presc_wrap ? '0 : presc_next[PRESCALE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
      end else if (advance && (item_ff.kind == KIND_TICK)) begin
         prescale_ff <= prescale_in;
      end
   end

   rtc_cal_step u_step (
      .cur         (time_ff),
      .item        (item_ff),
      .second_done (second_done),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= TIME_RESET;
      end else if (advance) begin
         time_ff <= step_result.now;
      end
   end

   // Two-entry result buffer.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= step_result;
      end
   end

   assign head = entry_ff[rd_ptr_ff];

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.out_second    = head.now.second;
   assign rsp_chan.out_minute    = head.now.minute;
   assign rsp_chan.out_hour      = head.now.hour;
   assign rsp_chan.out_day       = head.now.day;
   assign rsp_chan.out_month     = head.now.month;
   assign rsp_chan.out_year      = head.now.year;
   assign rsp_chan.out_leap      = head.now.leap;
   assign rsp_chan.second_strobe = head.second_strobe;
   assign rsp_chan.load_error    = head.load_error;

endmodule

[design/rtc_cal_step.sv]
// Next-state logic of the calendar: one-second advance with carry through
// all fields, and the checked load. Depends on rtc_cal_pkg.
module rtc_cal_step
   import rtc_cal_pkg::*;
(
   input  cal_time_type   cur,
   input  cal_item_type   item,
   input  logic           second_done,
   output cal_result_type result
);

   logic        sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
   logic [4:0]  month_len;
   logic [13:0] year_next;
   logic        load_leap;
   logic [4:0]  load_len;
   logic        load_ok;
   cal_time_type tick_time;

   assign month_len  = rtc_month_days(cur.month, cur.leap);
   assign sec_wrap   = (cur.second >= SEC_LAST);
   assign min_wrap   = sec_wrap && (cur.minute >= MIN_LAST);
   assign hour_wrap  = min_wrap && (cur.hour >= HOUR_LAST);
   assign day_wrap   = hour_wrap && (cur.day >= month_len);
   assign month_wrap = day_wrap && (cur.month >= MONTH_LAST);
   assign year_next  = (cur.year >= YEAR_LAST) ? 14'd0 : cur.year + 14'd1;

   always_comb begin
      tick_time = cur;
      if (second_done) begin
         tick_time.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
         if (sec_wrap) begin
            tick_time.minute = (cur.minute >= MIN_LAST) ? 6'd0 : cur.minute + 6'd1;
         end
         if (min_wrap) begin
            tick_time.hour = (cur.hour >= HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
         end
         if (hour_wrap) begin
            tick_time.day = (cur.day >= month_len) ? 5'd1 : cur.day + 5'd1;
         end
         if (day_wrap) begin
            tick_time.month = (cur.month >= MONTH_LAST) ? 4'd1 : cur.month + 4'd1;
         end
         if (month_wrap) begin
            tick_time.year = year_next;
            tick_time.leap = rtc_is_leap(year_next);
         end
      end
   end

   assign load_leap = rtc_is_leap(item.load_year);
   assign load_len  = rtc_month_days(item.load_month, load_leap);
   assign load_ok   = (item.load_second <= SEC_LAST) && (item.load_minute <= MIN_LAST) &&
                      (item.load_hour <= HOUR_LAST) && (item.load_month != 4'd0) &&
                      (item.load_month <= MONTH_LAST) && (item.load_year <= YEAR_LAST) &&
                      (item.load_day != 5'd0) && (item.load_day <= load_len);

   always_comb begin
      result.now           = cur;
      result.second_strobe = 1'b0;
      result.load_error    = 1'b0;
      if (item.kind == KIND_TICK) begin
         result.now           = tick_time;
         result.second_strobe = second_done;
      end else if (load_ok) begin
         result.now.second = item.load_second;
         result.now.minute = item.load_minute;
         result.now.hour   = item.load_hour;
         result.now.day    = item.load_day;
         result.now.month  = item.load_month;
         result.now.year   = item.load_year;
         result.now.leap   = load_leap;
      end else begin
         result.load_error = 1'b1;
      end
   end

endmodule
